// ===== design/tes_pkg.sv =====
// Shared types, constants and arithmetic tables for the trig equation solver.
`default_nettype none
package tes_pkg;
  localparam int FRAC_BITS_DEF     = 16;
  localparam int CORDIC_STAGES_DEF = 18;
  localparam int IN_W    = 18;
  localparam int ANG_W   = 19;
  localparam int TOL_W   = 16;
  localparam int GUARD   = 14;
  localparam int SQ_W    = 37;   // x1^2 + x2^2 fits in 36 bits, plus margin
  localparam int RT_W    = 19;   // floor sqrt of SQ_W-bit value
  localparam int CW      = 40;   // CORDIC datapath width
  localparam int ZW      = 34;   // binary angle width (full turn = 2^32)
  localparam logic signed [33:0] HALF_TURN = 34'sh0_8000_0000;
  localparam logic signed [33:0] FULL_TURN = 34'sh1_0000_0000;
  localparam logic [31:0] PI_Q29 = 32'd1686629713;

  typedef enum logic [1:0] {
    ST_TWO  = 2'd0,
    ST_INF  = 2'd1,
    ST_NONE = 2'd2
  } status_t;

  function automatic logic signed [ZW-1:0] atan_turn(input int i);
    logic [31:0] t;
    case (i)
      0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
      3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
      9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
      15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
      21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
      24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
      27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
      30: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return $signed({2'b00, t});
  endfunction
endpackage
`default_nettype wire

// ===== design/tes_if.sv =====
// Valid/ready stream interfaces for requests, results and configuration writes.
`default_nettype none
interface tes_in_if;
  logic valid;
  logic ready;
  logic signed [17:0] cos_coeff;
  logic signed [17:0] sin_coeff;
  logic signed [17:0] rhs_value;
  modport source (output valid, cos_coeff, sin_coeff, rhs_value, input ready);
  modport sink   (input valid, cos_coeff, sin_coeff, rhs_value, output ready);
endinterface

interface tes_out_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic signed [18:0] angle_first;
  logic signed [18:0] angle_second;
  modport source (output valid, status, angle_first, angle_second, input ready);
  modport sink   (input valid, status, angle_first, angle_second, output ready);
endinterface

interface tes_cfg_if;
  logic valid;
  logic ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== design/tes_sqrt_stage.sv =====
// One registered step of a pipelined floor square root (one result bit a stage).
`default_nettype none
module tes_sqrt_stage #(
  parameter int STEP = 0,
  parameter int PW   = 1
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [tes_pkg::SQ_W-1:0] rem_in,
  input  wire logic [tes_pkg::RT_W-1:0] root_in,
  input  wire logic [PW-1:0]            pass_in,
  output      logic [tes_pkg::SQ_W-1:0] rem_out,
  output      logic [tes_pkg::RT_W-1:0] root_out,
  output      logic [PW-1:0]            pass_out
);
  import tes_pkg::*;
  localparam int B = RT_W - 1 - STEP;
  logic [SQ_W+1:0] trial;
  logic [SQ_W+1:0] remw;
  always_comb begin
    trial = ({{(SQ_W+2-RT_W){1'b0}}, root_in} << (B + 1)) | ((SQ_W+2)'(1) << (2 * B));
    remw  = {2'b00, rem_in};
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pass_out <= pass_in;
      if (remw >= trial) begin
        rem_out  <= SQ_W'(remw - trial);
        root_out <= root_in | (RT_W'(1) << B);
      end else begin
        rem_out  <= rem_in;
        root_out <= root_in;
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/tes_cordic_stage.sv =====
// One registered micro-rotation of a vectoring CORDIC, carrying side payload.
`default_nettype none
module tes_cordic_stage #(
  parameter int STEP = 0,
  parameter int PW   = 1
) (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic signed [tes_pkg::CW-1:0]  x_in,
  input  wire logic signed [tes_pkg::CW-1:0]  y_in,
  input  wire logic signed [tes_pkg::ZW-1:0]  z_in,
  input  wire logic [PW-1:0]                  pass_in,
  output      logic signed [tes_pkg::CW-1:0]  x_out,
  output      logic signed [tes_pkg::CW-1:0]  y_out,
  output      logic signed [tes_pkg::ZW-1:0]  z_out,
  output      logic [PW-1:0]                  pass_out
);
  import tes_pkg::*;
  localparam logic signed [ZW-1:0] ATN = atan_turn(STEP);
  logic signed [CW-1:0] dx, dy;
  always_comb begin
    dx = y_in >>> STEP;
    dy = x_in >>> STEP;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pass_out <= pass_in;
      if (!y_in[CW-1]) begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + ATN;
      end else begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - ATN;
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/trig_equation_solver_unit.sv =====
// Top level of the pipelined harmonic-addition trig equation solver.
// Throughput one request per cycle while the output register is not stalled.
// The whole pipeline advances together whenever the output register is free,
//   so a stalled result holds every stage and nothing is lost or repeated.
// Reset (synchronous, active high) clears the valid registers and sets tolerance to 1.
`default_nettype none
module trig_equation_solver_unit #(
  parameter int FRAC_BITS     = tes_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = tes_pkg::CORDIC_STAGES_DEF
) (
  input wire logic clk,
  input wire logic rst,
  tes_in_if.sink   req,
  tes_out_if.source res,
  tes_cfg_if.sink  cfg
);
  import tes_pkg::*;

  localparam int NS   = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
  localparam int SH   = 60 - FRAC_BITS;
  // Pipeline depths of each section.
  localparam int D_SQ = RT_W;          // each root takes RT_W stages

  logic [TOL_W-1:0] tolerance;
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) tolerance <= TOL_W'(1);
    else if (cfg.valid) tolerance <= cfg.data;
  end

  // Global advance: the output register is free or being drained.
  logic adv;
  assign adv       = !res.valid || res.ready;
  assign req.ready = adv;

  // ---------------- Stage 0: squares ----------------
  logic               v0;
  logic signed [IN_W-1:0] x1_0, x2_0, y_0;
  logic [SQ_W-1:0]    r2_0, y2_0;
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (adv) v0 <= req.valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      x1_0 <= req.cos_coeff;
      x2_0 <= req.sin_coeff;
      y_0  <= req.rhs_value;
    end
  end
  // Stage 1: products registered (one multiplier each).
  logic signed [2*IN_W-1:0] p1_1, p2_1, py_1;
  logic               v1;
  logic signed [IN_W-1:0] x1_1, x2_1, y_1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= v0;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_1 <= x1_0 * x1_0;
      p2_1 <= x2_0 * x2_0;
      py_1 <= y_0 * y_0;
      x1_1 <= x1_0; x2_1 <= x2_0; y_1 <= y_0;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      r2_0 <= SQ_W'($unsigned(p1_1)) + SQ_W'($unsigned(p2_1));
      y2_0 <= SQ_W'($unsigned(py_1));
    end
  end
  logic v2;
  logic signed [IN_W-1:0] x1_2, x2_2, y_2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      x1_2 <= x1_1; x2_2 <= x2_1; y_2 <= y_1;
    end
  end

  // ---------------- First root: r = floor(sqrt(r2)) ----------------
  localparam int PA = 1 + 3 * IN_W + SQ_W;
  logic [SQ_W-1:0] ra_rem  [D_SQ+1];
  logic [RT_W-1:0] ra_root [D_SQ+1];
  logic [PA-1:0]   ra_pass [D_SQ+1];
  assign ra_rem[0]  = r2_0;
  assign ra_root[0] = '0;
  assign ra_pass[0] = {v2, x1_2, x2_2, y_2, y2_0};
  // r2 is carried too, for r2 - y2 later; keep in pass via separate line
  logic [SQ_W-1:0] r2_keep [D_SQ+1];
  assign r2_keep[0] = r2_0;
  for (genvar g = 0; g < D_SQ; g++) begin : g_ra
    tes_sqrt_stage #(.STEP(g), .PW(PA + SQ_W)) u_st (
      .clk(clk), .en(adv),
      .rem_in(ra_rem[g]), .root_in(ra_root[g]),
      .pass_in({ra_pass[g], r2_keep[g]}),
      .rem_out(ra_rem[g+1]), .root_out(ra_root[g+1]),
      .pass_out({ra_pass[g+1], r2_keep[g+1]})
    );
  end

  logic v3;
  logic signed [IN_W-1:0] x1_3, x2_3, y_3;
  logic [SQ_W-1:0] y2_3, r2_3;
  logic [RT_W-1:0] r_3;
  assign {v3, x1_3, x2_3, y_3, y2_3} = ra_pass[D_SQ];
  assign r2_3 = r2_keep[D_SQ];
  assign r_3  = ra_root[D_SQ];
  // valid bits travel in pass; reset is applied to the final valid outputs only
  // through the registered stage below (pass valid may be X after reset until flushed,
  // so mask with a reset-cleared shift line).
  logic [D_SQ-1:0] va_line;
  always_ff @(posedge clk) begin
    if (rst) va_line <= '0;
    else if (adv) va_line <= {va_line[D_SQ-2:0], v2};
  end

  // ---------------- Stage: classify ----------------
  logic v4;
  logic [1:0] st_4;
  logic solve_4;
  logic signed [IN_W-1:0] x1_4, x2_4, y_4;
  logic [SQ_W-1:0] d_4;
  logic [IN_W-1:0] ay;
  logic signed [RT_W+1:0] ovr;
  always_comb begin
    ay  = y_3[IN_W-1] ? IN_W'(-y_3) : IN_W'(y_3);
    ovr = $signed({3'b0, ay}) - $signed({2'b0, r_3});
  end
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= va_line[D_SQ-1] & v3;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      x1_4 <= x1_3; x2_4 <= x2_3; y_4 <= y_3;
      d_4  <= (r2_3 > y2_3) ? r2_3 - y2_3 : '0;
      solve_4 <= 1'b0;
      if (r_3 <= RT_W'(tolerance)) begin
        st_4 <= (ay <= IN_W'(tolerance)) ? ST_INF : ST_NONE;
      end else if (ovr > $signed({5'b0, tolerance})) begin
        st_4 <= ST_NONE;
      end else begin
        st_4 <= ST_TWO;
        solve_4 <= 1'b1;
      end
    end
  end

  // ---------------- Second root: s = floor(sqrt(d)) ----------------
  localparam int PB = 1 + 2 + 1 + 3 * IN_W;
  logic [SQ_W-1:0] rb_rem  [D_SQ+1];
  logic [RT_W-1:0] rb_root [D_SQ+1];
  logic [PB-1:0]   rb_pass [D_SQ+1];
  assign rb_rem[0]  = d_4;
  assign rb_root[0] = '0;
  assign rb_pass[0] = {v4, st_4, solve_4, x1_4, x2_4, y_4};
  for (genvar g = 0; g < D_SQ; g++) begin : g_rb
    tes_sqrt_stage #(.STEP(g), .PW(PB)) u_st (
      .clk(clk), .en(adv),
      .rem_in(rb_rem[g]), .root_in(rb_root[g]), .pass_in(rb_pass[g]),
      .rem_out(rb_rem[g+1]), .root_out(rb_root[g+1]), .pass_out(rb_pass[g+1])
    );
  end
  logic [D_SQ-1:0] vb_line;
  always_ff @(posedge clk) begin
    if (rst) vb_line <= '0;
    else if (adv) vb_line <= {vb_line[D_SQ-2:0], v4};
  end

  logic v5raw;
  logic [1:0] st_5;
  logic solve_5;
  logic signed [IN_W-1:0] x1_5, x2_5, y_5;
  logic [RT_W-1:0] s_5;
  assign {v5raw, st_5, solve_5, x1_5, x2_5, y_5} = rb_pass[D_SQ];
  assign s_5 = rb_root[D_SQ];

  // ---------------- CORDIC pre-rotation (both units) ----------------
  logic v6;
  logic [1:0] st_6;
  logic solve_6;
  logic signed [CW-1:0] ax_6, ay_6, bx_6, by_6;
  logic signed [ZW-1:0] az_6, bz_6;
  logic signed [CW-1:0] ax_s, ay_s, bx_s, by_s;
  always_comb begin
    ax_s = CW'(x1_5) <<< GUARD;
    ay_s = CW'(x2_5) <<< GUARD;
    bx_s = CW'(y_5)  <<< GUARD;
    by_s = $signed({{(CW-RT_W){1'b0}}, s_5}) <<< GUARD;
  end
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (adv) v6 <= vb_line[D_SQ-1] & v5raw;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      st_6 <= st_5; solve_6 <= solve_5;
      if (ax_s[CW-1]) begin
        az_6 <= ay_s[CW-1] ? -HALF_TURN : HALF_TURN;
        ax_6 <= -ax_s; ay_6 <= -ay_s;
      end else begin
        az_6 <= '0; ax_6 <= ax_s; ay_6 <= ay_s;
      end
      if (bx_s[CW-1]) begin
        bz_6 <= by_s[CW-1] ? -HALF_TURN : HALF_TURN;
        bx_6 <= -bx_s; by_6 <= -by_s;
      end else begin
        bz_6 <= '0; bx_6 <= bx_s; by_6 <= by_s;
      end
    end
  end

  // ---------------- CORDIC stages ----------------
  localparam int PC = 2 + 1;
  logic signed [CW-1:0] cax [NS+1], cay [NS+1], cbx [NS+1], cby [NS+1];
  logic signed [ZW-1:0] caz [NS+1], cbz [NS+1];
  logic [PC-1:0] cpass [NS+1];
  logic unused_b [NS+1];
  assign cax[0] = ax_6; assign cay[0] = ay_6; assign caz[0] = az_6;
  assign cbx[0] = bx_6; assign cby[0] = by_6; assign cbz[0] = bz_6;
  assign cpass[0] = {st_6, solve_6};
  assign unused_b[0] = 1'b0;
  for (genvar g = 0; g < NS; g++) begin : g_cd
    tes_cordic_stage #(.STEP(g), .PW(PC)) u_a (
      .clk(clk), .en(adv),
      .x_in(cax[g]), .y_in(cay[g]), .z_in(caz[g]), .pass_in(cpass[g]),
      .x_out(cax[g+1]), .y_out(cay[g+1]), .z_out(caz[g+1]), .pass_out(cpass[g+1])
    );
    tes_cordic_stage #(.STEP(g), .PW(1)) u_b (
      .clk(clk), .en(adv),
      .x_in(cbx[g]), .y_in(cby[g]), .z_in(cbz[g]), .pass_in(unused_b[g]),
      .x_out(cbx[g+1]), .y_out(cby[g+1]), .z_out(cbz[g+1]), .pass_out(unused_b[g+1])
    );
  end
  logic [NS-1:0] vc_line;
  always_ff @(posedge clk) begin
    if (rst) vc_line <= '0;
    else if (adv) vc_line <= {vc_line[NS-2:0], v6};
  end
  logic [1:0] st_7;
  logic solve_7;
  assign {st_7, solve_7} = cpass[NS];

  // ---------------- Root differences and wrap ----------------
  logic v8;
  logic [1:0] st_8;
  logic solve_8;
  logic signed [ZW-1:0] d1_8, d2_8;
  function automatic logic signed [ZW-1:0] wrap(input logic signed [ZW+1:0] d);
    logic signed [ZW+1:0] w;
    w = d;
    if (w > (ZW+2)'(HALF_TURN)) w = w - (ZW+2)'(FULL_TURN);
    if (w < -(ZW+2)'(HALF_TURN)) w = w + (ZW+2)'(FULL_TURN);
    return ZW'(w);
  endfunction
  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (adv) v8 <= vc_line[NS-1];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      st_8 <= st_7; solve_8 <= solve_7;
      d1_8 <= wrap((ZW+2)'(cbz[NS]) - (ZW+2)'(caz[NS]));
      d2_8 <= wrap(-(ZW+2)'(cbz[NS]) - (ZW+2)'(caz[NS]));
    end
  end

  // ---------------- Scale to radians (one multiplier each) ----------------
  logic v9;
  logic [1:0] st_9;
  logic solve_9;
  logic signed [ZW+32:0] m1_9, m2_9;
  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (adv) v9 <= v8;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      st_9 <= st_8; solve_9 <= solve_8;
      m1_9 <= (ZW+33)'(d1_8) * $signed({1'b0, PI_Q29});
      m2_9 <= (ZW+33)'(d2_8) * $signed({1'b0, PI_Q29});
    end
  end

  // ---------------- Round and output register ----------------
  logic signed [ZW+32:0] rnd1, rnd2;
  always_comb begin
    rnd1 = (m1_9 + ((ZW+33)'(1) <<< (SH - 1))) >>> SH;
    rnd2 = (m2_9 + ((ZW+33)'(1) <<< (SH - 1))) >>> SH;
  end
  always_ff @(posedge clk) begin
    if (rst) res.valid <= 1'b0;
    else if (adv) res.valid <= v9;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      res.status       <= st_9;
      res.angle_first  <= solve_9 ? ANG_W'(rnd1) : '0;
      res.angle_second <= solve_9 ? ANG_W'(rnd2) : '0;
    end
  end
endmodule
`default_nettype wire

// ===== design/tes_checker.sv =====
// Port-level checker for the trig equation solver, bound to the top level.
`default_nettype none
module tes_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [18:0] angle_first,
  input wire logic [18:0] angle_second
);
  import tes_pkg::*;
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_TWO || status == ST_INF || status == ST_NONE))
    else $error("bad status code");
  a_zero_angles: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_TWO |-> angle_first == '0 && angle_second == '0)
    else $error("angles not zero without solutions");
  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(in_valid && in_ready))
    else $error("input accepted while pipeline held");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("stalled result changed");
endmodule

bind trig_equation_solver_unit tes_checker u_tes_checker (
  .clk(clk), .rst(rst),
  .in_valid(req.valid), .in_ready(req.ready),
  .out_valid(res.valid), .out_ready(res.ready),
  .status(res.status), .angle_first(res.angle_first), .angle_second(res.angle_second)
);
`default_nettype wire
